// ----- rtl/core/slx_pkg.sv -----
// slx_pkg: shared types, constants and keyword table of the SQL lexer stream core.
// Depends on nothing; used by every module of the core.
`timescale 1ns / 1ps
package slx_pkg;

    localparam int KW_COUNT    = 35;
    localparam int KW_MAX      = 9;
    localparam int REC_MAX     = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int POS_BITS    = 16;

    localparam logic [5:0] NOT_KW = 6'(KW_COUNT);

    localparam logic [2:0] T_END     = 3'd0;
    localparam logic [2:0] T_KEYWORD = 3'd1;
    localparam logic [2:0] T_IDENT   = 3'd2;
    localparam logic [2:0] T_NUMBER  = 3'd3;
    localparam logic [2:0] T_STRING  = 3'd4;
    localparam logic [2:0] T_OPER    = 3'd5;
    localparam logic [2:0] T_SYMBOL  = 3'd6;
    localparam logic [2:0] T_UNKNOWN = 3'd7;

    localparam logic REC_CONTENT = 1'b0;
    localparam logic REC_TOKEN   = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [2:0]  ttype;
        logic [7:0]  content;
        logic [5:0]  kw;
        logic [15:0] start;
        logic [15:0] len;
        logic        last;
    } rec_t;

    // all records caused by one input item
    typedef struct packed {
        rec_t [REC_MAX-1:0] rec;
        logic [2:0]         cnt;
    } bundle_t;

    function automatic logic [8*KW_MAX-1:0] kw_text(input int i);
        logic [8*KW_MAX-1:0] t;
        begin
            case (i)
                0:  t = "CREATE";
                1:  t = "DATABASE";
                2:  t = "TABLE";
                3:  t = "INSERT";
                4:  t = "INTO";
                5:  t = "VALUES";
                6:  t = "SELECT";
                7:  t = "FROM";
                8:  t = "WHERE";
                9:  t = "AND";
                10: t = "OR";
                11: t = "NOT";
                12: t = "PRIMARY";
                13: t = "KEY";
                14: t = "UNIQUE";
                15: t = "NULL";
                16: t = "INT";
                17: t = "INTEGER";
                18: t = "FLOAT";
                19: t = "DOUBLE";
                20: t = "CHAR";
                21: t = "VARCHAR";
                22: t = "BOOL";
                23: t = "BOOLEAN";
                24: t = "DATE";
                25: t = "DATETIME";
                26: t = "USE";
                27: t = "SHOW";
                28: t = "DATABASES";
                29: t = "TABLES";
                30: t = "DROP";
                31: t = "DELETE";
                32: t = "UPDATE";
                33: t = "SET";
                34: t = "DEFAULT";
                default: t = '0;
            endcase
            return t;
        end
    endfunction

    // word holds uppercased bytes, byte 0 first; len above KW_MAX never matches
    function automatic logic [5:0] kw_lookup(input logic [KW_MAX-1:0][7:0] word,
                                             input logic [3:0] len);
        logic [8*KW_MAX-1:0] t;
        logic [8*KW_MAX-1:0] tl;
        int                  l;
        logic                ok;
        logic [5:0]          idx;
        begin
            idx = NOT_KW;
            for (int i = KW_COUNT - 1; i >= 0; i--) begin
                t = kw_text(i);
                l = 0;
                for (int j = 0; j < KW_MAX; j++) begin
                    if (t[8*j +: 8] != 8'd0) l = j + 1;
                end
                tl = t << (8 * (KW_MAX - l));
                ok = (int'(len) == l) && (l != 0);
                for (int j = 0; j < KW_MAX; j++) begin
                    if (j < l && word[j] != tl[8*KW_MAX-1-8*j -: 8]) ok = 1'b0;
                end
                if (ok) idx = 6'(i);
            end
            return idx;
        end
    endfunction

endpackage

// ----- rtl/core/slx_front.sv -----
// slx_front: lexer state machine; takes one byte item a cycle while the queue has room and builds its records.
// Depends on slx_pkg; feeds slx_queue.
`timescale 1ns / 1ps
module slx_front #(
    parameter int POSITION_BITS = slx_pkg::POS_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       char_byte,
    input  logic             has_char,
    input  logic             end_of_text,
    input  logic             q_full,
    output logic             push,
    output slx_pkg::bundle_t push_data
);
    import slx_pkg::*;

    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_NUM, M_NUM_DOT, M_STR, M_STR_BS, M_STR_Q,
        M_LINE, M_BLOCK, M_BLOCK_STAR,
        M_P_MINUS, M_P_SLASH, M_P_LT, M_P_GT, M_P_BANG, M_P_BAR, M_P_AMP
    } mode_t;

    localparam logic [POSITION_BITS-1:0] PMAX = '1;

    mode_t                       mode_reg, mode_next;
    logic [7:0]                  quote_reg, quote_next;
    logic [POSITION_BITS-1:0]    pos_reg, pos_next;
    logic [POSITION_BITS-1:0]    start_reg, start_next;
    logic [3:0]                  wlen_reg, wlen_next;
    logic [KW_MAX-1:0][7:0]      wbuf_reg, wbuf_next;

    logic [REC_MAX-1:0][$bits(rec_t)-1:0] recs;
    logic [2:0]                  n;
    logic [POSITION_BITS-1:0]    cur, nxt;
    logic                        idle_start, str_again;
    logic [7:0]                  c;
    logic                        accept;

    function automatic logic [15:0] clamp(input logic [POSITION_BITS-1:0] v);
        logic [32:0] w;
        begin
            w = 33'(v);
            return (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
        end
    endfunction

    function automatic rec_t tok_rec(input logic [2:0] ty, input logic [5:0] kw,
                                     input logic [POSITION_BITS-1:0] so,
                                     input logic [POSITION_BITS-1:0] e);
        rec_t r;
        begin
            r.kind    = REC_TOKEN;
            r.ttype   = ty;
            r.content = 8'd0;
            r.kw      = kw;
            r.start   = clamp(so);
            r.len     = (e >= so) ? clamp(e - so) : 16'd0;
            r.last    = 1'b0;
            return r;
        end
    endfunction

    function automatic rec_t cont_rec(input logic [7:0] ch,
                                      input logic [POSITION_BITS-1:0] so);
        rec_t r;
        begin
            r.kind    = REC_CONTENT;
            r.ttype   = T_STRING;
            r.content = ch;
            r.kw      = NOT_KW;
            r.start   = clamp(so);
            r.len     = 16'd0;
            r.last    = 1'b0;
            return r;
        end
    endfunction

    function automatic logic is_ident(input logic [7:0] ch);
        return (ch inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], 8'h5F});
    endfunction

    assign c        = char_byte;
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        mode_next  = mode_reg;
        quote_next = quote_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        wlen_next  = wlen_reg;
        wbuf_next  = wbuf_reg;
        recs       = '0;
        n          = 3'd0;
        cur        = pos_reg;
        nxt        = (pos_reg < PMAX) ? pos_reg + 1'b1 : pos_reg;
        idle_start = 1'b0;
        str_again  = 1'b0;
        if (has_char) begin
            case (mode_reg)
                M_IDENT:
                begin
                    if (is_ident(c)) begin
                        if (wlen_next < 4'(KW_MAX)) begin
                            wbuf_next[wlen_next] = (c inside {[8'h61:8'h7A]}) ? c - 8'd32 : c;
                            wlen_next = wlen_next + 4'd1;
                        end else begin
                            wlen_next = 4'(KW_MAX + 1);
                        end
                    end else begin
                        if (kw_lookup(wbuf_next, wlen_next) == NOT_KW)
                            recs[n[1:0]] = tok_rec(T_IDENT, NOT_KW, start_next, cur);
                        else
                            recs[n[1:0]] = tok_rec(T_KEYWORD, kw_lookup(wbuf_next, wlen_next),
                                                   start_next, cur);
                        n = n + 3'd1;
                        idle_start = 1'b1;
                    end
                end
                M_NUM, M_NUM_DOT:
                begin
                    if (c inside {[8'h30:8'h39]}) begin
                    end else if (c == 8'h2E && mode_reg == M_NUM) begin
                        mode_next = M_NUM_DOT;
                    end else begin
                        recs[n[1:0]] = tok_rec(T_NUMBER, NOT_KW, start_next, cur);
                        n = n + 3'd1;
                        idle_start = 1'b1;
                    end
                end
                M_STR:
                    str_again = 1'b1;
                M_STR_BS:
                begin
                    if (c == quote_reg) begin
                        recs[n[1:0]] = cont_rec(c, start_next);
                        n = n + 3'd1;
                        mode_next = M_STR;
                    end else begin
                        // lone backslash is literal content, byte handled afresh
                        recs[n[1:0]] = cont_rec(8'h5C, start_next);
                        n = n + 3'd1;
                        str_again = 1'b1;
                    end
                end
                M_STR_Q:
                begin
                    if (c == quote_reg) begin
                        recs[n[1:0]] = cont_rec(c, start_next);
                        n = n + 3'd1;
                        mode_next = M_STR;
                    end else begin
                        recs[n[1:0]] = tok_rec(T_STRING, NOT_KW, start_next, cur);
                        n = n + 3'd1;
                        idle_start = 1'b1;
                    end
                end
                M_LINE:
                    if (c == 8'h0A) mode_next = M_IDLE;
                M_BLOCK:
                    if (c == 8'h2A) mode_next = M_BLOCK_STAR;
                M_BLOCK_STAR:
                begin
                    if (c == 8'h2F) mode_next = M_IDLE;
                    else if (c != 8'h2A) mode_next = M_BLOCK;
                end
                M_P_MINUS, M_P_SLASH:
                begin
                    if (mode_reg == M_P_MINUS && c == 8'h2D) begin
                        mode_next = M_LINE;
                    end else if (mode_reg == M_P_SLASH && c == 8'h2A) begin
                        mode_next = M_BLOCK;
                    end else begin
                        recs[n[1:0]] = tok_rec(T_OPER, NOT_KW, start_next, cur);
                        n = n + 3'd1;
                        idle_start = 1'b1;
                    end
                end
                M_P_LT, M_P_GT, M_P_BANG, M_P_BAR, M_P_AMP:
                begin
                    if ((mode_reg == M_P_LT && (c == 8'h3D || c == 8'h3E)) ||
                        ((mode_reg == M_P_GT || mode_reg == M_P_BANG) && c == 8'h3D) ||
                        (mode_reg == M_P_BAR && c == 8'h7C) ||
                        (mode_reg == M_P_AMP && c == 8'h26)) begin
                        recs[n[1:0]] = tok_rec(T_OPER, NOT_KW, start_next, nxt);
                        n = n + 3'd1;
                        mode_next = M_IDLE;
                    end else begin
                        recs[n[1:0]] = tok_rec((mode_reg == M_P_LT || mode_reg == M_P_GT)
                                               ? T_OPER : T_UNKNOWN, NOT_KW, start_next, cur);
                        n = n + 3'd1;
                        idle_start = 1'b1;
                    end
                end
                default:
                    idle_start = 1'b1;
            endcase

            if (str_again) begin
                if (c == 8'h5C) begin
                    mode_next = M_STR_BS;
                end else if (c == quote_reg) begin
                    mode_next = M_STR_Q;
                end else begin
                    mode_next = M_STR;
                    recs[n[1:0]] = cont_rec(c, start_next);
                    n = n + 3'd1;
                end
            end

            if (idle_start) begin
                mode_next  = M_IDLE;
                start_next = cur;
                if (c inside {8'h20, [8'h09:8'h0D]}) begin
                end else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F}) begin
                    mode_next    = M_IDENT;
                    wbuf_next[0] = (c inside {[8'h61:8'h7A]}) ? c - 8'd32 : c;
                    wlen_next    = 4'd1;
                end else if (c inside {[8'h30:8'h39]}) begin
                    mode_next = M_NUM;
                end else if (c == 8'h27 || c == 8'h22) begin
                    quote_next = c;
                    mode_next  = M_STR;
                end else if (c == 8'h2D) begin
                    mode_next = M_P_MINUS;
                end else if (c == 8'h2F) begin
                    mode_next = M_P_SLASH;
                end else if (c == 8'h3C) begin
                    mode_next = M_P_LT;
                end else if (c == 8'h3E) begin
                    mode_next = M_P_GT;
                end else if (c == 8'h21) begin
                    mode_next = M_P_BANG;
                end else if (c == 8'h7C) begin
                    mode_next = M_P_BAR;
                end else if (c == 8'h26) begin
                    mode_next = M_P_AMP;
                end else begin
                    recs[n[1:0]] = tok_rec((c inside {8'h3D, 8'h2B, 8'h2A, 8'h25}) ? T_OPER :
                                           (c inside {8'h28, 8'h29, 8'h2C, 8'h3B, 8'h2E})
                                           ? T_SYMBOL : T_UNKNOWN, NOT_KW, cur, nxt);
                    n = n + 3'd1;
                end
            end
            pos_next = nxt;
        end

        if (end_of_text) begin
            case (mode_next)
                M_IDENT:
                begin
                    if (kw_lookup(wbuf_next, wlen_next) == NOT_KW)
                        recs[n[1:0]] = tok_rec(T_IDENT, NOT_KW, start_next, pos_next);
                    else
                        recs[n[1:0]] = tok_rec(T_KEYWORD, kw_lookup(wbuf_next, wlen_next),
                                               start_next, pos_next);
                    n = n + 3'd1;
                end
                M_NUM, M_NUM_DOT:
                begin
                    recs[n[1:0]] = tok_rec(T_NUMBER, NOT_KW, start_next, pos_next);
                    n = n + 3'd1;
                end
                M_STR_BS:
                begin
                    recs[n[1:0]] = cont_rec(8'h5C, start_next);
                    n = n + 3'd1;
                    recs[n[1:0]] = tok_rec(T_UNKNOWN, NOT_KW, start_next, pos_next);
                    n = n + 3'd1;
                end
                M_STR, M_P_BANG, M_P_BAR, M_P_AMP:
                begin
                    recs[n[1:0]] = tok_rec(T_UNKNOWN, NOT_KW, start_next, pos_next);
                    n = n + 3'd1;
                end
                M_STR_Q:
                begin
                    recs[n[1:0]] = tok_rec(T_STRING, NOT_KW, start_next, pos_next);
                    n = n + 3'd1;
                end
                M_P_MINUS, M_P_SLASH, M_P_LT, M_P_GT:
                begin
                    recs[n[1:0]] = tok_rec(T_OPER, NOT_KW, start_next, pos_next);
                    n = n + 3'd1;
                end
                default:
                begin
                end
            endcase
            recs[n[1:0]] = {REC_TOKEN, T_END, 8'd0, NOT_KW, clamp(pos_next), 16'd0, 1'b1};
            n = n + 3'd1;
            mode_next  = M_IDLE;
            quote_next = 8'd0;
            pos_next   = '0;
            start_next = '0;
            wlen_next  = 4'd0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < REC_MAX; i++) push_data.rec[i] = rec_t'(recs[i]);
        push_data.cnt = n;
    end

    assign push = accept && (n != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= M_IDLE;
            quote_reg <= 8'd0;
            pos_reg   <= '0;
            start_reg <= '0;
            wlen_reg  <= 4'd0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            wlen_reg  <= wlen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) wbuf_reg <= wbuf_next;
    end

endmodule

// ----- rtl/core/slx_queue.sv -----
// slx_queue: short queue of record bundles between lexer front and output back end.
// Depends on slx_pkg.
`timescale 1ns / 1ps
module slx_queue #(
    parameter int DEPTH = slx_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  slx_pkg::bundle_t push_data,
    output logic             full,
    output logic             head_valid,
    output slx_pkg::bundle_t head,
    input  logic             pop
);
    import slx_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t         mem [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   cnt_reg;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full       = (cnt_reg == CW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= inc(wr_reg);
            if (pop) rd_reg <= inc(rd_reg);
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/core/slx_back.sv -----
// slx_back: walks the records of the head bundle into the output register, one a cycle unless the receiver stalls.
// Depends on slx_pkg; drains slx_queue.
`timescale 1ns / 1ps
module slx_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  slx_pkg::bundle_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output slx_pkg::rec_t    out_rec
);
    import slx_pkg::*;

    logic [1:0] sub_reg;
    logic       ov_reg;
    rec_t       rec_reg;
    logic       load;
    logic       at_end;

    assign load      = !ov_reg || out_ready;
    assign at_end    = ({1'b0, sub_reg} == head.cnt - 3'd1);
    assign pop       = load && head_valid && at_end;
    assign out_valid = ov_reg;
    assign out_rec   = rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ov_reg  <= 1'b0;
            sub_reg <= 2'd0;
        end else if (load) begin
            ov_reg <= head_valid;
            if (head_valid) sub_reg <= at_end ? 2'd0 : sub_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid) rec_reg <= head.rec[sub_reg];
    end

endmodule

// ----- rtl/core/sql_lexer_stream_core.sv -----
// sql_lexer_stream_core: streaming SQL tokenizer, one text byte per input item.
// Depends on slx_pkg, slx_front, slx_queue and slx_back.
//
// Input channel (in_valid/in_ready): char_byte, has_char, end_of_text. An item with
// has_char low and end_of_text low is a no-op. end_of_text closes the open token,
// emits an end record with last high and returns the lexer to offset 0.
// Output channel (out_valid/out_ready): one record per transfer, either a decoded
// string byte (record_kind 0) or a finished token (record_kind 1).
// Throughput: one input item per cycle while the bundle queue has room; one record
// per cycle out while the receiver is ready. An item yields zero to four records, so
// the output port sets the sustained rate when items average more than one record.
// An accepted item's records are written to the bundle queue at the accepting edge;
// the output register then loads them from the queue head, one at a time.
// A stalled receiver holds the output register; the four-deep bundle queue keeps
// taking items until it fills, then in_ready drops.
// Reset clears the lexer state, the queue and the output valid; no clearing pass.
`timescale 1ns / 1ps
module sql_lexer_stream_core #(
    parameter int POSITION_BITS = slx_pkg::POS_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_byte,
    input  logic        has_char,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        record_kind,
    output logic [2:0]  token_type,
    output logic [7:0]  content_byte,
    output logic [5:0]  keyword_index,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        last
);
    import slx_pkg::*;

    logic    push, q_full, head_valid, pop;
    bundle_t push_data, head;
    rec_t    out_rec;

    slx_front #(.POSITION_BITS(POSITION_BITS)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .char_byte, .has_char, .end_of_text,
        .q_full, .push, .push_data
    );

    slx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk, .rst_n, .push, .push_data, .full(q_full), .head_valid, .head, .pop
    );

    slx_back u_back (
        .clk, .rst_n, .head_valid, .head, .pop, .out_valid, .out_ready, .out_rec
    );

    assign record_kind   = out_rec.kind;
    assign token_type    = out_rec.ttype;
    assign content_byte  = out_rec.content;
    assign keyword_index = out_rec.kw;
    assign token_start   = out_rec.start;
    assign token_length  = out_rec.len;
    assign last          = out_rec.last;

endmodule

// ----- rtl/core/slx_checker.sv -----
// slx_checker: port-level assertions for sql_lexer_stream_core, bound to the top level.
// Depends on slx_pkg.
`timescale 1ns / 1ps
module slx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        record_kind,
    input logic [2:0]  token_type,
    input logic [5:0]  keyword_index,
    input logic [15:0] token_length,
    input logic        last
);
    import slx_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_type) && $stable(last))
        else $error("output item dropped or changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> record_kind == REC_TOKEN && token_type == T_END)
        else $error("last set on a non-end record");

    a_content: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind == REC_CONTENT |->
            token_type == T_STRING && token_length == 16'd0 && keyword_index == NOT_KW)
        else $error("malformed string content item");

    a_kw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_type == T_KEYWORD) == (keyword_index == NOT_KW) |-> 1'b0)
        else $error("keyword index disagrees with token type");

endmodule

bind sql_lexer_stream_core slx_checker u_slx_checker (
    .clk, .rst_n, .out_valid, .out_ready, .record_kind, .token_type,
    .keyword_index, .token_length, .last
);
